// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RSPA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RSPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSPA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RSPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- sv/rspa_pkg.sv -----
// ----------------------------------------------------------------------------
// rspa_pkg
// types and constants of the slot pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package rspa_pkg;

    localparam int POOL_SLOTS_DEF  = 256;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAP_WORD_W      = 32;  // in-use bits per map word
    localparam int MAP_BIT_W       = 5;   // bit index inside a map word

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_INC   = 3'd2,
        OP_DEC   = 3'd3,
        OP_CLEAR = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_ZERO      = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] slot;
    } t_req;

    typedef struct packed {
        logic [7:0]  slot_out;
        logic [1:0]  status;
        logic [15:0] count_after;
        logic        slot_freed;
    } t_rsp;

    typedef struct packed {
        t_status status;
        logic    clr_bit;   // clear the in-use bit
        logic    freed;     // the bit went from one to zero
    } t_alu_flags;

endpackage

`default_nettype wire

// ----- sv/rspa_ffz.sv -----
// ----------------------------------------------------------------------------
// rspa_ffz
// lowest free bit of one in-use map word
// ----------------------------------------------------------------------------
`default_nettype none

module rspa_ffz #(
    parameter int LAST_BITS = rspa_pkg::MAP_WORD_W
) (
    input  wire logic [rspa_pkg::MAP_WORD_W-1:0] i_word,
    input  wire logic                            i_last,
    output logic                                 o_found,
    output logic [rspa_pkg::MAP_BIT_W-1:0]       o_bit
);
    import rspa_pkg::*;

    logic [MAP_WORD_W-1:0] w_busy;

    // bits past the end of the pool count as taken
    always_comb begin
        for (int b = 0; b < MAP_WORD_W; b++) begin
            w_busy[b] = i_word[b] | (i_last && (b >= LAST_BITS));
        end
    end

    always_comb begin
        o_found = 1'b0;
        o_bit   = '0;
        for (int b = MAP_WORD_W - 1; b >= 0; b--) begin
            if (!w_busy[b]) begin
                o_found = 1'b1;
                o_bit   = MAP_BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/rspa_alu.sv -----
// ----------------------------------------------------------------------------
// rspa_alu
// shared reference count update for free, increment and decrement
// ----------------------------------------------------------------------------
`default_nettype none

module rspa_alu #(
    parameter int COUNT_WIDTH = rspa_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic [2:0]             i_op,
    input  wire logic [COUNT_WIDTH-1:0] i_count,
    input  wire logic                   i_in_use,
    output logic [COUNT_WIDTH-1:0]      o_count,
    output rspa_pkg::t_alu_flags        o_flags
);
    import rspa_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CONE = COUNT_WIDTH'(1);

    always_comb begin
        o_count         = i_count;
        o_flags.status  = ST_OK;
        o_flags.clr_bit = 1'b0;
        o_flags.freed   = 1'b0;
        unique case (i_op)
            OP_FREE: begin
                o_count         = '0;
                o_flags.clr_bit = 1'b1;
                o_flags.freed   = i_in_use;
            end
            OP_INC: begin
                // saturate at the top
                if (i_count == CMAX) begin
                    o_flags.status = ST_SATURATED;
                end else begin
                    o_count = i_count + CONE;
                end
            end
            OP_DEC: begin
                if (i_count == '0) begin
                    o_flags.status = ST_ZERO;
                end else begin
                    o_count = i_count - CONE;
                    if (i_count == CONE) begin
                        o_flags.clr_bit = 1'b1;
                        o_flags.freed   = i_in_use;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/refcounted_slot_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// refcounted_slot_pool_allocator
// pool of slots with in-use bits and saturating reference counts
// ----------------------------------------------------------------------------
// usage
//   request channel: i_in_valid / o_in_stall carry opcode and slot index
//   response channel: o_out_valid / i_out_stall carry one result per request
//   one request is worked on at a time; o_in_stall is high while it runs
//   free, increment, decrement: map word and count are read at transfer, updated
//     in S_RMW, and the result is loaded into the output register from S_EMIT
//   allocate: scans the map word by word, at most POOL_SLOTS/32 words rounded up
//     (8 for 256 slots), one word per read of the registered map read port
//   clear pool: clears one count entry a cycle over all POOL_SLOTS entries,
//     then the result
//   undefined opcode or index past the pool: no state change
//   after reset the same clearing pass runs with o_in_stall high and no result
//   a result waits in the output register while i_out_stall is high; a new
//     request is still taken meanwhile and stops before its result until
//     the register frees up
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module refcounted_slot_pool_allocator #(
    parameter int POOL_SLOTS  = rspa_pkg::POOL_SLOTS_DEF,
    parameter int COUNT_WIDTH = rspa_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire rspa_pkg::t_req i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output rspa_pkg::t_rsp     o_out_data,
    input  wire logic          i_out_stall
);
    import rspa_pkg::*;

    localparam int SLOT_W    = $clog2(POOL_SLOTS);
    localparam int NUM_WORDS = (POOL_SLOTS + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LAST_BITS = POOL_SLOTS - (NUM_WORDS - 1) * MAP_WORD_W;

    localparam logic [SLOT_W-1:0] CLR_LAST   = SLOT_W'(POOL_SLOTS - 1);
    localparam logic [SLOT_W-1:0] WORDS_END  = SLOT_W'(NUM_WORDS);
    localparam logic [WI_W-1:0]   WORD_LAST  = WI_W'(NUM_WORDS - 1);
    localparam logic [31:0]       SLOT_LIMIT = 32'(POOL_SLOTS);
    localparam logic [15:0]       CNT_MAX16  = 16'({COUNT_WIDTH{1'b1}});

    // state and working registers
    t_state                  r_state, n_state;
    logic [2:0]              r_op, n_op;
    logic [7:0]              r_slot, n_slot;
    logic [WI_W-1:0]         r_word, n_word;
    logic [SLOT_W-1:0]       r_clr_idx, n_clr_idx;
    logic                    r_clr_emit, n_clr_emit;
    t_rsp                    r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_rsp                    r_out_data, n_out_data;

    // in-use map, one 32-bit word per row, and count memory
    logic [MAP_WORD_W-1:0]   r_map_mem [NUM_WORDS];
    logic [MAP_WORD_W-1:0]   r_map_rdata;
    logic [COUNT_WIDTH-1:0]  r_cnt_mem [POOL_SLOTS];
    logic [COUNT_WIDTH-1:0]  r_cnt_rdata;

    logic                    map_we;
    logic [WI_W-1:0]         map_waddr, map_raddr;
    logic [MAP_WORD_W-1:0]   map_wdata;
    logic                    cnt_we;
    logic [SLOT_W-1:0]       cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0]  cnt_wdata;

    logic                    in_xfer;
    logic                    out_free;
    logic                    slot_ok;
    logic                    scan_last;
    logic                    ffz_found;
    logic [MAP_BIT_W-1:0]    ffz_bit;
    logic [COUNT_WIDTH-1:0]  alu_count;
    t_alu_flags              alu_flags;
    logic                    alu_in_use;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // index must name a slot of the pool
    assign slot_ok    = ({24'd0, i_in_data.slot} < SLOT_LIMIT);
    assign scan_last  = (r_word == WORD_LAST);
    assign alu_in_use = r_map_rdata[r_slot[MAP_BIT_W-1:0]];

    // free-bit search over the current map word
    rspa_ffz #(
        .LAST_BITS (LAST_BITS)
    ) u_ffz (
        .i_word  (r_map_rdata),
        .i_last  (scan_last),
        .o_found (ffz_found),
        .o_bit   (ffz_bit)
    );

    // shared count update unit
    rspa_alu #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_alu (
        .i_op     (r_op),
        .i_count  (r_cnt_rdata),
        .i_in_use (alu_in_use),
        .o_count  (alu_count),
        .o_flags  (alu_flags)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == CLR_LAST) begin
                    n_state = r_clr_emit ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    priority if (i_in_data.opcode == OP_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (i_in_data.opcode == OP_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (i_in_data.opcode > OP_CLEAR || !slot_ok) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_RMW;
                    end
                end
            end
            S_SCAN: begin
                if (ffz_found || scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_RMW: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op        = r_op;
        n_slot      = r_slot;
        n_word      = r_word;
        n_clr_idx   = r_clr_idx;
        n_clr_emit  = r_clr_emit;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        map_we      = 1'b0;
        map_waddr   = '0;
        map_wdata   = '0;
        map_raddr   = '0;
        cnt_we      = 1'b0;
        cnt_waddr   = '0;
        cnt_wdata   = '0;
        cnt_raddr   = '0;
        unique case (r_state)
            S_CLEAR: begin
                // one count entry a cycle, map rows while the index covers them
                cnt_we    = 1'b1;
                cnt_waddr = r_clr_idx;
                if (r_clr_idx < WORDS_END) begin
                    map_we    = 1'b1;
                    map_waddr = r_clr_idx[WI_W-1:0];
                end
                if (r_clr_idx == CLR_LAST) begin
                    n_clr_idx  = '0;
                    n_clr_emit = 1'b0;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_op   = i_in_data.opcode;
                    n_slot = i_in_data.slot;
                    n_word = '0;
                    n_res  = '0;
                    priority if (i_in_data.opcode == OP_ALLOC) begin
                        map_raddr = '0;
                    end else if (i_in_data.opcode == OP_CLEAR) begin
                        n_clr_idx  = '0;
                        n_clr_emit = 1'b1;
                    end else if (i_in_data.opcode > OP_CLEAR) begin
                        n_res = '0;
                    end else if (!slot_ok) begin
                        n_res.slot_out = i_in_data.slot;
                    end else begin
                        n_res.slot_out = i_in_data.slot;
                        map_raddr = WI_W'(i_in_data.slot[7:MAP_BIT_W]);
                        cnt_raddr = SLOT_W'(i_in_data.slot);
                    end
                end
            end
            S_SCAN: begin
                if (ffz_found) begin
                    map_we    = 1'b1;
                    map_waddr = r_word;
                    map_wdata = r_map_rdata | (MAP_WORD_W'(1) << ffz_bit);
                    cnt_we    = 1'b1;
                    cnt_waddr = SLOT_W'({r_word, ffz_bit});
                    cnt_wdata = COUNT_WIDTH'(1);
                    n_res.slot_out    = 8'({r_word, ffz_bit});
                    n_res.status      = ST_OK;
                    n_res.count_after = 16'd1;
                    n_res.slot_freed  = 1'b0;
                end else if (scan_last) begin
                    n_res        = '0;
                    n_res.status = ST_EXHAUSTED;
                end else begin
                    n_word    = r_word + 1'b1;
                    map_raddr = r_word + 1'b1;
                end
            end
            S_RMW: begin
                cnt_we    = 1'b1;
                cnt_waddr = SLOT_W'(r_slot);
                cnt_wdata = alu_count;
                map_we    = alu_flags.clr_bit;
                map_waddr = WI_W'(r_slot[7:MAP_BIT_W]);
                map_wdata = r_map_rdata & ~(MAP_WORD_W'(1) << r_slot[MAP_BIT_W-1:0]);
                n_res.status      = alu_flags.status;
                n_res.count_after = 16'(alu_count);
                n_res.slot_freed  = alu_flags.freed;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_clr_emit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_emit  <= n_clr_emit;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_slot     <= n_slot;
        r_word     <= n_word;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // memories, registered read
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        r_map_rdata <= r_map_mem[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rdata <= r_cnt_mem[cnt_raddr];
    end

    // checks
    `RSPA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_xfer, o_in_stall, "request taken while busy")
    `RSPA_ASSERT_IMP(a_exhausted_clean, i_clk, i_rst_n, o_out_valid && o_out_data.status == ST_EXHAUSTED, o_out_data.slot_out == 8'd0 && o_out_data.count_after == 16'd0, "exhausted result carries data")
    `RSPA_ASSERT_IMP(a_freed_zero, i_clk, i_rst_n, o_out_valid && o_out_data.slot_freed, o_out_data.status == ST_OK && o_out_data.count_after == 16'd0, "release with nonzero count")
    `RSPA_ASSERT_IMP(a_sat_max, i_clk, i_rst_n, o_out_valid && o_out_data.status == ST_SATURATED, o_out_data.count_after == CNT_MAX16, "saturated count not at maximum")

endmodule

`default_nettype wire

// ----- sim/refcounted_slot_pool_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_pool_allocator_tb
// self-checking bench for the slot pool allocator: a directed table, then
// random lifecycles, pool fills and a long response hold, all checked
// against a cycle-free model of the pool
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_slot_pool_allocator_tb;

    import rspa_pkg::*;

    // pool geometry as built by default
    localparam int          POOL_N       = POOL_SLOTS_DEF;
    localparam logic [15:0] COUNT_TOP    = 16'hFFFF;
    // opcodes the block treats as no-ops
    localparam logic [2:0]  OP_UNDEF_LO  = 3'd5;
    localparam logic [2:0]  OP_UNDEF_HI  = 3'd7;
    localparam int          MAX_WAIT     = 14;
    localparam int          LONG_HOLD    = 300;
    localparam int          BLOCKS       = 14;
    localparam int          BLOCK_ITEMS  = 30;
    localparam int          BURST_ITEMS  = 30;
    // a clear pass is the slowest operation, allow two of them
    localparam int          DRAIN_CYCLES = 2 * POOL_N + 16;
    localparam t_rsp        ANY_RSP      = '0;

    typedef logic [7:0] t_slot_q [$];

    // one row of the directed table; pinned rows carry a hand-written result
    typedef struct {
        t_req req;
        bit   pinned;
        t_rsp rsp;
    } t_probe;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_req i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out_data;

    // mirror of the pool state
    bit          slot_live [POOL_N];
    logic [15:0] slot_refs [POOL_N];

    // results owed by the block, oldest first
    t_rsp owed_rsps [$];
    int   mismatches   = 0;

    // idling controls, flipped by the stimulus per block
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    bit rx_long_hold = 1'b0;

    // directed table: some ignored slot fields carry 8'hA5 / 8'h5A so every slot bit
    // toggles; the typed results are the ones readable at a glance
    t_probe probes [21] = '{
        // first allocate after reset lands on slot zero
        '{'{OP_ALLOC, 8'hA5}, 1'b1, '{8'd0, ST_OK, 16'd1, 1'b0}},
        '{'{OP_ALLOC, 8'h00}, 1'b1, '{8'd1, ST_OK, 16'd1, 1'b0}},
        '{'{OP_INC,   8'd0},  1'b0, ANY_RSP},
        '{'{OP_INC,   8'd1},  1'b0, ANY_RSP},
        '{'{OP_DEC,   8'd1},  1'b0, ANY_RSP},
        // down to zero releases the slot
        '{'{OP_DEC,   8'd1},  1'b0, ANY_RSP},
        // decrement at zero
        '{'{OP_DEC,   8'd1},  1'b1, '{8'd1, ST_ZERO, 16'd0, 1'b0}},
        // increment of a slot that was never allocated
        '{'{OP_INC,   8'hFF}, 1'b1, '{8'hFF, ST_OK, 16'd1, 1'b0}},
        // back to zero on an unused slot: nothing to release
        '{'{OP_DEC,   8'hFF}, 1'b1, '{8'hFF, ST_OK, 16'd0, 1'b0}},
        // free of an unused slot
        '{'{OP_FREE,  8'd128}, 1'b1, '{8'd128, ST_OK, 16'd0, 1'b0}},
        '{'{OP_FREE,  8'd0},  1'b1, '{8'd0, ST_OK, 16'd0, 1'b1}},
        '{'{OP_ALLOC, 8'hFF}, 1'b0, ANY_RSP},
        '{'{OP_INC,   8'hFF}, 1'b0, ANY_RSP},
        // undefined opcodes do nothing
        '{'{OP_UNDEF_LO, 8'hFF}, 1'b1, '0},
        '{'{OP_UNDEF_HI, 8'h00}, 1'b1, '0},
        // clear pool empties everything
        '{'{OP_CLEAR, 8'h5A}, 1'b1, '0},
        '{'{OP_DEC,   8'd0},  1'b1, '{8'd0, ST_ZERO, 16'd0, 1'b0}},
        '{'{OP_INC,   8'hFF}, 1'b1, '{8'hFF, ST_OK, 16'd1, 1'b0}},
        '{'{OP_ALLOC, 8'h5A}, 1'b1, '{8'd0, ST_OK, 16'd1, 1'b0}},
        '{'{OP_FREE,  8'd0},  1'b0, ANY_RSP},
        // second free of the same slot
        '{'{OP_FREE,  8'd0},  1'b1, '{8'd0, ST_OK, 16'd0, 1'b0}}
    };

    refcounted_slot_pool_allocator dut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .i_in_data,
        .o_in_stall,
        .o_out_valid,
        .o_out_data,
        .i_out_stall
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // pool model
    // ------------------------------------------------------------------------

    function automatic void pool_clear();
        int k;
        for (k = 0; k < POOL_N; k++) begin
            slot_live[k] = 1'b0;
            slot_refs[k] = '0;
        end
    endfunction

    // applies one request to the mirror and returns the result it owes
    function automatic t_rsp pool_apply(input t_req r);
        t_rsp       e;
        logic [7:0] idx;
        bit         found;
        int         k;
        e     = '0;
        idx   = r.slot;
        found = 1'b0;
        // every 8-bit index lies inside the 256-slot pool, so no range check
        case (r.opcode)
            OP_ALLOC: begin
                e.status = ST_EXHAUSTED;
                for (k = 0; k < POOL_N; k++) begin
                    if (!found && !slot_live[k]) begin
                        found         = 1'b1;
                        slot_live[k]  = 1'b1;
                        slot_refs[k]  = 16'd1;
                        e.slot_out    = 8'(k);
                        e.status      = ST_OK;
                        e.count_after = 16'd1;
                    end
                end
            end
            OP_FREE: begin
                e.slot_out     = idx;
                e.slot_freed   = slot_live[idx];
                slot_live[idx] = 1'b0;
                slot_refs[idx] = '0;
            end
            OP_INC: begin
                e.slot_out = idx;
                // saturate instead of wrapping
                if (slot_refs[idx] == COUNT_TOP) begin
                    e.status = ST_SATURATED;
                end else begin
                    slot_refs[idx] = slot_refs[idx] + 16'd1;
                end
                e.count_after = slot_refs[idx];
            end
            OP_DEC: begin
                e.slot_out = idx;
                if (slot_refs[idx] == '0) begin
                    e.status = ST_ZERO;
                end else begin
                    slot_refs[idx] = slot_refs[idx] - 16'd1;
                    // the last reference gone releases the slot
                    if (slot_refs[idx] == '0) begin
                        e.slot_freed   = slot_live[idx];
                        slot_live[idx] = 1'b0;
                    end
                    e.count_after = slot_refs[idx];
                end
            end
            OP_CLEAR: begin
                pool_clear();
            end
            default: begin
            end
        endcase
        return e;
    endfunction

    function automatic t_slot_q live_slots();
        t_slot_q q;
        int      k;
        for (k = 0; k < POOL_N; k++) begin
            if (slot_live[k]) begin
                q.push_back(8'(k));
            end
        end
        return q;
    endfunction

    // random request, mostly aimed at slots that are currently allocated
    function automatic t_req pick_req();
        t_req    r;
        t_slot_q live;
        int      roll;
        live   = live_slots();
        roll   = $urandom_range(0, 99);
        r.slot = 8'($urandom_range(0, 255));
        if (roll < 30) begin
            r.opcode = OP_ALLOC;
        end else if (roll < 50) begin
            r.opcode = OP_INC;
        end else if (roll < 75) begin
            r.opcode = OP_DEC;
        end else if (roll < 87) begin
            r.opcode = OP_FREE;
        end else if (roll < 89) begin
            r.opcode = OP_CLEAR;
        end else if (roll < 92) begin
            r.opcode = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        end else begin
            // noise: anything at all
            r.opcode = 3'($urandom_range(0, 7));
        end
        if (roll < 87 && live.size() > 0 && $urandom_range(0, 9) != 0) begin
            r.slot = live[$urandom_range(0, live.size() - 1)];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offers one request, waits for its transfer, then books the result
    task automatic send_req(input t_req r, input bit pinned, input t_rsp pinned_rsp);
        int   gap;
        t_rsp e;
        gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        // the model moves on even when the row pins its own result
        e = pool_apply(r);
        owed_rsps.push_back(pinned ? pinned_rsp : e);
    endtask

    // allocate until the pool runs dry, push past it, then hand some back
    task automatic fill_pool();
        t_slot_q live;
        int      n;
        live = live_slots();
        while (live.size() < POOL_N) begin
            send_req(t_req'{OP_ALLOC, 8'($urandom_range(0, 255))}, 1'b0, ANY_RSP);
            live = live_slots();
        end
        for (n = 0; n < 3; n++) begin
            send_req(t_req'{OP_ALLOC, 8'($urandom_range(0, 255))}, 1'b0, ANY_RSP);
        end
        for (n = 0; n < 12; n++) begin
            send_req(t_req'{OP_FREE, 8'($urandom_range(0, 255))}, 1'b0, ANY_RSP);
            send_req(t_req'{OP_ALLOC, 8'($urandom_range(0, 255))}, 1'b0, ANY_RSP);
        end
    endtask

    // ------------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_rsp(input t_rsp got);
        t_rsp want;
        if (owed_rsps.size() == 0) begin
            report_mismatch("unexpected result, slot_out", got.slot_out, 0);
            return;
        end
        want = owed_rsps.pop_front();
        if (got.slot_out !== want.slot_out)
            report_mismatch("slot_out", got.slot_out, want.slot_out);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.count_after !== want.count_after)
            report_mismatch("count_after", got.count_after, want.count_after);
        if (got.slot_freed !== want.slot_freed)
            report_mismatch("slot_freed", got.slot_freed, want.slot_freed);
    endtask

    // every result transfer is checked against the oldest booked result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_rsp(o_out_data);
        end
    end

    // receiver: random hold before each result, one long hold on request
    initial begin : rx_side
        int hold;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_long_hold) begin
                hold         = LONG_HOLD;
                rx_long_hold = 1'b0;
            end else begin
                hold = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial begin : stim
        int blk;
        int n;
        pool_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; the block's clearing pass after reset just stalls us
        foreach (probes[n]) begin
            send_req(probes[n].req, probes[n].pinned, probes[n].rsp);
        end

        // random blocks; each picks its own idling so some run back to back
        for (blk = 0; blk < BLOCKS; blk++) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (blk == 3 || blk == 10) begin
                fill_pool();
            end else if (blk == 6) begin
                // long response hold while requests keep coming back to back
                tx_idle      = 1'b0;
                rx_long_hold = 1'b1;
                for (n = 0; n < BURST_ITEMS; n++) begin
                    send_req(pick_req(), 1'b0, ANY_RSP);
                end
            end else begin
                for (n = 0; n < BLOCK_ITEMS; n++) begin
                    send_req(pick_req(), 1'b0, ANY_RSP);
                end
            end
        end
        i_in_valid <= 1'b0;

        // drain, then give a late or extra result time to show up
        while (owed_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin : watchdog
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
